/* src/pmc3_pkg.sv */
// ----------------------------------------------------------------------------
// pmc3_pkg
// shared types and constants for the 3d point mean and covariance block
// ----------------------------------------------------------------------------
package pmc3_pkg;

  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic               last_point;
  } pmc3_in_t;

  typedef struct packed {
    logic signed [15:0] mean_x;
    logic signed [15:0] mean_y;
    logic signed [15:0] mean_z;
    logic        [30:0] cov_xx;
    logic signed [31:0] cov_xy;
    logic signed [31:0] cov_xz;
    logic        [30:0] cov_yy;
    logic signed [31:0] cov_yz;
    logic        [30:0] cov_zz;
    logic               overflow;
  } pmc3_out_t;

  // totals of one finished set, handed from front to back
  typedef struct packed {
    logic        [16:0] cnt;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [32:0] sz;
    logic signed [47:0] pxx;
    logic signed [47:0] pxy;
    logic signed [47:0] pxz;
    logic signed [47:0] pyy;
    logic signed [47:0] pyz;
    logic signed [47:0] pzz;
    logic               drop;
  } pmc3_set_t;

  localparam int QDEPTH = 2;

endpackage

/* src/pmc3_accum.sv */
// ----------------------------------------------------------------------------
// pmc3_accum
// front part: takes points, accumulates sums, pushes totals on the last point
// ----------------------------------------------------------------------------
module pmc3_accum #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  pmc3_pkg::pmc3_in_t  pt,
  output logic                push,
  output pmc3_pkg::pmc3_set_t set_out
);
  import pmc3_pkg::*;

  pmc3_set_t acc_r, acc_nxt;
  logic signed [31:0] mxx, mxy, mxz, myy, myz, mzz;
  logic               room;

  assign room = (acc_r.cnt < 17'(MAX_POINTS));
  assign mxx = 32'(pt.coord_x * pt.coord_x);
  assign mxy = 32'(pt.coord_x * pt.coord_y);
  assign mxz = 32'(pt.coord_x * pt.coord_z);
  assign myy = 32'(pt.coord_y * pt.coord_y);
  assign myz = 32'(pt.coord_y * pt.coord_z);
  assign mzz = 32'(pt.coord_z * pt.coord_z);

  always_comb begin
    acc_nxt = acc_r;
    if (room) begin
      acc_nxt.cnt = acc_r.cnt + 17'd1;
      acc_nxt.sx  = acc_r.sx + 33'(pt.coord_x);
      acc_nxt.sy  = acc_r.sy + 33'(pt.coord_y);
      acc_nxt.sz  = acc_r.sz + 33'(pt.coord_z);
      acc_nxt.pxx = acc_r.pxx + 48'(mxx);
      acc_nxt.pxy = acc_r.pxy + 48'(mxy);
      acc_nxt.pxz = acc_r.pxz + 48'(mxz);
      acc_nxt.pyy = acc_r.pyy + 48'(myy);
      acc_nxt.pyz = acc_r.pyz + 48'(myz);
      acc_nxt.pzz = acc_r.pzz + 48'(mzz);
    end else begin
      acc_nxt.drop = 1'b1;
    end
  end

  assign push    = take && pt.last_point;
  assign set_out = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      acc_r <= '0;
    end else if (take) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* src/pmc3_queue.sv */
// ----------------------------------------------------------------------------
// pmc3_queue
// short fifo of finished set totals between front and back
// ----------------------------------------------------------------------------
module pmc3_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pmc3_pkg::pmc3_set_t din,
  input  logic                pop,
  output logic                empty,
  output logic                full,
  output pmc3_pkg::pmc3_set_t dout
);
  import pmc3_pkg::*;

  pmc3_set_t   mem_r [QDEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'(QDEPTH));
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

/* src/pmc3_solve.sv */
// ----------------------------------------------------------------------------
// pmc3_solve
// back part: products, then radix-2 restoring divides for means and covariances
// ----------------------------------------------------------------------------
module pmc3_solve (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          ridge,
  input  logic                 avail,
  input  pmc3_pkg::pmc3_set_t  set_in,
  output logic                 pop,
  output logic                 out_valid,
  output pmc3_pkg::pmc3_out_t  out_data
);
  import pmc3_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_N2, S_PROD, S_NUM, S_DIV, S_NEXT, S_DONE} st_t;

  st_t                st_r;
  pmc3_set_t          set_r;
  logic [33:0]        nsq_r;       // n*n, up to 2^32
  logic [3:0]         job_r;       // 0..2 means, 3..8 covariances
  logic signed [65:0] pa_r, pb_r;  // n*Sij and Si*Sj
  logic [65:0]        rem_r;
  logic [65:0]        quo_r;
  logic               neg_r;
  logic [6:0]         bit_r;
  logic [65:0]        den_r;
  pmc3_out_t          res_r;

  logic signed [32:0] si, sj;
  logic signed [47:0] sp;
  logic [66:0]        trial;
  logic signed [65:0] num;
  logic signed [65:0] sq;
  logic signed [31:0] qs;

  always_comb begin
    si = set_r.sx; sj = set_r.sx; sp = set_r.pxx;
    unique case (job_r)
      4'd3: begin si = set_r.sx; sj = set_r.sx; sp = set_r.pxx; end
      4'd4: begin si = set_r.sx; sj = set_r.sy; sp = set_r.pxy; end
      4'd5: begin si = set_r.sx; sj = set_r.sz; sp = set_r.pxz; end
      4'd6: begin si = set_r.sy; sj = set_r.sy; sp = set_r.pyy; end
      4'd7: begin si = set_r.sy; sj = set_r.sz; sp = set_r.pyz; end
      4'd8: begin si = set_r.sz; sj = set_r.sz; sp = set_r.pzz; end
      4'd1: si = set_r.sy;
      4'd2: si = set_r.sz;
      default: si = set_r.sx;
    endcase
  end

  assign num   = (job_r < 4'd3) ? 66'(si) : (pa_r - pb_r);
  assign trial = {rem_r, quo_r[65]} - {1'b0, den_r};
  assign sq    = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign qs    = 32'(sq);
  assign pop   = (st_r == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (st_r == S_DONE);
      unique case (st_r)
        S_IDLE: if (avail) begin
          set_r <= set_in;
          job_r <= 4'd0;
          st_r  <= S_N2;
        end
        S_N2: begin
          nsq_r <= 34'(set_r.cnt * set_r.cnt);
          st_r  <= S_PROD;
        end
        S_PROD: begin
          pa_r <= 66'($signed({1'b0, set_r.cnt}) * sp);
          pb_r <= 66'(si * sj);
          st_r <= S_NUM;
        end
        S_NUM: begin
          rem_r <= '0;
          den_r <= (job_r < 4'd3) ? 66'(set_r.cnt) : 66'(nsq_r);
          bit_r <= 7'd66;
          if (set_r.cnt == 17'd0) begin
            neg_r <= 1'b0;
            quo_r <= '0;
            st_r  <= S_NEXT;
          end else begin
            neg_r <= num[65];
            quo_r <= num[65] ? 66'(-num) : num;
            st_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (!trial[66]) begin
            rem_r <= trial[65:0];
            quo_r <= {quo_r[64:0], 1'b1};
          end else begin
            rem_r <= {rem_r[64:0], quo_r[65]};
            quo_r <= {quo_r[64:0], 1'b0};
          end
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd1) st_r <= S_NEXT;
        end
        S_NEXT: begin
          unique case (job_r)
            4'd0: res_r.mean_x <= qs[15:0];
            4'd1: res_r.mean_y <= qs[15:0];
            4'd2: res_r.mean_z <= qs[15:0];
            4'd3: res_r.cov_xx <= 31'(qs + 32'(ridge));
            4'd4: res_r.cov_xy <= qs;
            4'd5: res_r.cov_xz <= qs;
            4'd6: res_r.cov_yy <= 31'(qs + 32'(ridge));
            4'd7: res_r.cov_yz <= qs;
            default: res_r.cov_zz <= 31'(qs + 32'(ridge));
          endcase
          res_r.overflow <= set_r.drop;
          job_r <= job_r + 4'd1;
          st_r  <= (job_r == 4'd8) ? S_DONE : S_PROD;
        end
        S_DONE: begin
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_data = res_r;

endmodule

/* src/point_mean_covariance_3d.sv */
// ----------------------------------------------------------------------------
// point_mean_covariance_3d
// streaming sample mean and 3x3 covariance of sets of 3d points
// ----------------------------------------------------------------------------
// usage
//   input: a point transfers at a clock edge with start high and busy low;
//   in_data.last_point closes the set
//   points are taken one per cycle; busy rises only when the two-deep queue
//   of set totals between accumulator and divider is full
//   output: out_valid is high for one cycle with out_data; no stall possible
//   sequence: after the edge taking the last point, the divider pops the
//   set totals, squares n, then runs 9 jobs, each of products, numerator,
//   66 radix-2 divide steps (none for an empty set), store; then the strobe
//   the shared divider takes a new set only after the last one is done;
//   sets that arrive meanwhile back up in the queue, then busy holds
//   cfg_we writes the ridge added to the diagonal; write only while idle
//   reset clears accumulators, queue and divider; ridge returns to 1
// ----------------------------------------------------------------------------
module point_mean_covariance_3d #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pmc3_pkg::pmc3_in_t  in_data,
  output logic                out_valid,
  output pmc3_pkg::pmc3_out_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import pmc3_pkg::*;

  logic      [15:0] ridge_r;
  logic             take, push, pop, q_empty, q_full;
  pmc3_set_t        set_f, set_b;

  // full queue stalls the front
  assign busy = q_full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridge_r <= 16'd1;
    end else if (cfg_we) begin
      ridge_r <= cfg_data;
    end
  end

  pmc3_accum #(.MAX_POINTS(MAX_POINTS)) u_accum (
    .clk(clk), .rst_n(rst_n), .take(take), .pt(in_data),
    .push(push), .set_out(set_f)
  );

  pmc3_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .din(set_f), .pop(pop),
    .empty(q_empty), .full(q_full), .dout(set_b)
  );

  pmc3_solve u_solve (
    .clk(clk), .rst_n(rst_n), .ridge(ridge_r), .avail(!q_empty),
    .set_in(set_b), .pop(pop), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
